// ----- hw/rtl/brl_pkg.sv -----
// Package with shared constants, types and helpers of the line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package brl_pkg;

    localparam int TILE_SIZE   = 64;
    localparam int COORD_W     = 6;
    localparam int COLOUR_W    = 24;
    localparam int ERR_W       = 9;

    localparam logic [COORD_W-1:0]  COORD_MAX    = COORD_W'(TILE_SIZE - 1);
    localparam logic [COLOUR_W-1:0] COLOUR_RESET = 24'hFFFFFF;

    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [COLOUR_W-1:0] colour_t;
    typedef logic signed [ERR_W-1:0] err_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;
    } dp_status_t;

    // Saturate a coordinate to the tile
    function automatic coord_t clip_coord(input coord_t c);
        coord_t r;
        r = c;
        if ({1'b0, c} > {1'b0, COORD_MAX})
        begin
            r = COORD_MAX;
        end
        return r;
    endfunction

    function automatic coord_t abs_diff(input coord_t a, input coord_t b);
        coord_t r;
        if (a > b)
        begin
            r = a - b;
        end
        else
        begin
            r = b - a;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/brl_if.sv -----
// Handshake interfaces for line requests and emitted pixels.
`timescale 1ns / 1ps
`default_nettype none

interface brl_req_if;
    logic            valid;
    logic            ready;
    brl_pkg::coord_t start_x;
    brl_pkg::coord_t start_y;
    brl_pkg::coord_t end_x;
    brl_pkg::coord_t end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, output ready);
endinterface

interface brl_pix_if;
    logic             valid;
    logic             ready;
    brl_pkg::coord_t  pixel_x;
    brl_pkg::coord_t  pixel_y;
    brl_pkg::colour_t colour;
    logic             last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output colour,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input colour,
                    input last_pixel, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/brl_ctrl.sv -----
// Controller state machine that sequences one line walk at a time.
`timescale 1ns / 1ps
`default_nettype none

module brl_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire brl_pkg::dp_status_t status,
    output brl_pkg::dp_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode handshakes and commands
    always_comb
    begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.step = 1'b1;
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request and pixel channels open at once");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (in_valid && in_ready))
        else $error("load without accepted request");

    a_step_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (out_valid && out_ready))
        else $error("step without accepted pixel");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status.last) |=> in_ready)
        else $error("not idle after final pixel");

    a_load_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid)
        else $error("no pixel after request load");

endmodule

`default_nettype wire

// ----- hw/rtl/brl_datapath.sv -----
// Datapath holding the walk position, error term and colour register.
`timescale 1ns / 1ps
`default_nettype none

module brl_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire brl_pkg::dp_cmd_t     cmd,
    output brl_pkg::dp_status_t       status,
    input  wire brl_pkg::coord_t      start_x,
    input  wire brl_pkg::coord_t      start_y,
    input  wire brl_pkg::coord_t      end_x,
    input  wire brl_pkg::coord_t      end_y,
    input  wire logic                 cfg_we,
    input  wire brl_pkg::colour_t     cfg_wdata,
    output brl_pkg::coord_t           pixel_x,
    output brl_pkg::coord_t           pixel_y,
    output brl_pkg::colour_t          colour,
    output logic                      last_pixel
);

    brl_pkg::coord_t  cur_major_reg,   cur_major_next;
    brl_pkg::coord_t  cur_minor_reg,   cur_minor_next;
    brl_pkg::coord_t  end_major_reg,   end_major_next;
    brl_pkg::coord_t  delta_major_reg, delta_major_next;
    brl_pkg::coord_t  delta_minor_reg, delta_minor_next;
    brl_pkg::err_t    error_reg,       error_next;
    logic             minor_down_reg,  minor_down_next;
    logic             x_is_major_reg,  x_is_major_next;
    brl_pkg::colour_t colour_reg;

    brl_pkg::coord_t sx, sy, ex, ey;
    brl_pkg::coord_t a_major, a_minor, b_major, b_minor;
    brl_pkg::coord_t ld_dmajor, ld_dminor;
    logic            ld_x_major;
    logic            last;

    // Clip the endpoints and pick the major axis
    always_comb
    begin
        sx = brl_pkg::clip_coord(start_x);
        sy = brl_pkg::clip_coord(start_y);
        ex = brl_pkg::clip_coord(end_x);
        ey = brl_pkg::clip_coord(end_y);
        ld_x_major = brl_pkg::abs_diff(sy, ey) < brl_pkg::abs_diff(sx, ex);
        if (ld_x_major)
        begin
            a_major = sx; a_minor = sy; b_major = ex; b_minor = ey;
        end
        else
        begin
            a_major = sy; a_minor = sx; b_major = ey; b_minor = ex;
        end
        // Swap so the major coordinate rises
        if (a_major > b_major)
        begin
            {a_major, b_major} = {b_major, a_major};
            {a_minor, b_minor} = {b_minor, a_minor};
        end
        ld_dmajor = b_major - a_major;
        ld_dminor = brl_pkg::abs_diff(a_minor, b_minor);
    end

    assign last = (cur_major_reg == end_major_reg);

    // Load a new line or advance one pixel
    always_comb
    begin
        cur_major_next   = cur_major_reg;
        cur_minor_next   = cur_minor_reg;
        end_major_next   = end_major_reg;
        delta_major_next = delta_major_reg;
        delta_minor_next = delta_minor_reg;
        error_next       = error_reg;
        minor_down_next  = minor_down_reg;
        x_is_major_next  = x_is_major_reg;
        if (cmd.load)
        begin
            cur_major_next   = a_major;
            cur_minor_next   = a_minor;
            end_major_next   = b_major;
            delta_major_next = ld_dmajor;
            delta_minor_next = ld_dminor;
            minor_down_next  = (b_minor < a_minor);
            x_is_major_next  = ld_x_major;
            error_next = $signed({2'b00, ld_dminor, 1'b0}) - $signed({3'b000, ld_dmajor});
        end
        else if (cmd.step)
        begin
            if (error_reg > 0)
            begin
                if (minor_down_reg)
                begin
                    cur_minor_next = cur_minor_reg - 1'b1;
                end
                else
                begin
                    cur_minor_next = cur_minor_reg + 1'b1;
                end
                error_next = error_reg
                           + $signed({2'b00, delta_minor_reg, 1'b0})
                           - $signed({2'b00, delta_major_reg, 1'b0});
            end
            else
            begin
                error_next = error_reg + $signed({2'b00, delta_minor_reg, 1'b0});
            end
            if (!last)
            begin
                cur_major_next = cur_major_reg + 1'b1;
            end
        end
    end

    // Hold the walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_major_reg   <= '0;
            cur_minor_reg   <= '0;
            end_major_reg   <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            error_reg       <= '0;
            minor_down_reg  <= 1'b0;
            x_is_major_reg  <= 1'b0;
        end
        else
        begin
            cur_major_reg   <= cur_major_next;
            cur_minor_reg   <= cur_minor_next;
            end_major_reg   <= end_major_next;
            delta_major_reg <= delta_major_next;
            delta_minor_reg <= delta_minor_next;
            error_reg       <= error_next;
            minor_down_reg  <= minor_down_next;
            x_is_major_reg  <= x_is_major_next;
        end
    end

    // Hold the colour register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg <= brl_pkg::COLOUR_RESET;
        end
        else if (cfg_we)
        begin
            colour_reg <= cfg_wdata;
        end
    end

    // Map the walk position back to x and y
    assign pixel_x     = x_is_major_reg ? cur_major_reg : cur_minor_reg;
    assign pixel_y     = x_is_major_reg ? cur_minor_reg : cur_major_reg;
    assign colour      = colour_reg;
    assign last_pixel  = last;
    assign status.last = last;

endmodule

`default_nettype wire

// ----- hw/rtl/bresenham_line_rasterizer.sv -----
// Top level of the Bresenham line rasterizer.
//
// A line request (start_x, start_y, end_x, end_y) enters on line_req; every
// pixel of the line leaves on pixel, in order of rising major coordinate,
// with the colour register attached and last_pixel set on the final one.
// The user must write the colour register with cfg_we/cfg_wdata only
// while idle; the block does not enforce this. The first pixel is valid
// in the cycle after the request transaction. Throughput: one pixel per
// cycle while the receiver is ready; a line of 1 to 64 pixels is walked
// by the single walk register set, which the controller steps per pixel.
// A new request is taken only once the final pixel transaction is done.
// When the receiver stalls, the current pixel holds and the walk waits.
// Reset clears the walk state, returns to idle with line_req.ready high,
// and sets the colour register to white (0xFFFFFF).
// Coordinates at or above the tile size are saturated to its last column.
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_rasterizer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    brl_req_if.sink               line_req,
    brl_pix_if.source             pixel,
    input  wire logic             cfg_we,
    input  wire brl_pkg::colour_t cfg_wdata
);

    brl_pkg::dp_cmd_t    cmd;
    brl_pkg::dp_status_t status;
    logic                req_ready;
    logic                pix_valid;

    // Sequence the line walk
    brl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (line_req.valid),
        .in_ready  (req_ready),
        .out_valid (pix_valid),
        .out_ready (pixel.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Compute pixel positions
    brl_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .start_x    (line_req.start_x),
        .start_y    (line_req.start_y),
        .end_x      (line_req.end_x),
        .end_y      (line_req.end_y),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .pixel_x    (pixel.pixel_x),
        .pixel_y    (pixel.pixel_y),
        .colour     (pixel.colour),
        .last_pixel (pixel.last_pixel)
    );

    assign line_req.ready = req_ready;
    assign pixel.valid    = pix_valid;

endmodule

`default_nettype wire
